// ===== hw/rtl/stg_pkg.sv =====
// ----------------------------------------------------------------------------
// stg_pkg
// shared constants, types and register codes for the sine tone generator
// ----------------------------------------------------------------------------
package stg_pkg;

  typedef longint unsigned u64_t;

  // default sizes
  localparam int MAX_CHANNELS_DEF       = 8;
  localparam int SINE_TABLE_ENTRIES_DEF = 1024;

  // field widths
  localparam int SAMPLE_W    = 16;
  localparam int AMP_W       = 15;
  localparam int PHASE_W     = 32;
  localparam int CHAN_CNT_W  = 4;
  localparam int CHAN_IDX_W  = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // fixed point constants for the table build, q30
  localparam u64_t HALF_PI_Q30 = 64'd1686629713;
  localparam u64_t Q30_ONE     = 64'd1073741824;

  // register reset values
  localparam logic [PHASE_W-1:0]    PHASE_INC_RST = 32'd42852281;
  localparam logic [AMP_W-1:0]      AMPLITUDE_RST = 15'd0;
  localparam logic [CHAN_CNT_W-1:0] CHAN_CNT_RST  = 4'd2;

  // register index codes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC     = 2'd0,
    CFG_AMPLITUDE     = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_t;

endpackage

// ===== hw/rtl/stg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// stg_sine_rom
// full-wave sine table in signed q1.15, one registered read port
// ----------------------------------------------------------------------------
module stg_sine_rom #(
  parameter int ENTRIES = stg_pkg::SINE_TABLE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(ENTRIES)-1:0]          rd_addr,
  output logic signed [stg_pkg::SAMPLE_W-1:0] rd_data
);

  typedef logic signed [stg_pkg::SAMPLE_W-1:0] rom_t [ENTRIES];

  // quarter-wave symmetry plus taylor series to x^11 in q30, products truncated
  function automatic logic signed [stg_pkg::SAMPLE_W-1:0] sine_entry(
    input stg_pkg::u64_t k
  );
    stg_pkg::u64_t u;
    stg_pkg::u64_t q;
    stg_pkg::u64_t r;
    stg_pkg::u64_t a;
    stg_pkg::u64_t x;
    stg_pkg::u64_t x2;
    stg_pkg::u64_t term;
    stg_pkg::u64_t mq;
    longint        sum;
    logic signed [stg_pkg::SAMPLE_W-1:0] m;
    u    = 4 * k;
    q    = u / ENTRIES;
    r    = u % ENTRIES;
    a    = q[0] ? (stg_pkg::u64_t'(ENTRIES) - r) : r;
    x    = (a * stg_pkg::HALF_PI_Q30) / ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    if (sum < 0) sum = 0;
    if (sum > longint'(2 * stg_pkg::Q30_ONE)) sum = longint'(2 * stg_pkg::Q30_ONE);
    mq = (stg_pkg::u64_t'(sum) + 64'd16384) >> 15;
    if (mq > 64'd32767) mq = 64'd32767;
    m = stg_pkg::SAMPLE_W'(mq);
    return q[1] ? -m : m;
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < ENTRIES; i++) begin
      t[i] = sine_entry(stg_pkg::u64_t'(i));
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ROM[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/sine_tone_generator_core.sv =====
// ----------------------------------------------------------------------------
// sine_tone_generator_core
// direct digital synthesis tone source, one audio frame per input item
// ----------------------------------------------------------------------------
// Each input item asks for one frame. The 32-bit phase accumulator sits in a
// one-entry synchronous memory; the phase maps to a sine table entry, which is
// scaled by the amplitude and truncated toward zero. The sample then goes out
// once per channel (channel_count, 0 read as 1, saturated at MAX_CHANNELS),
// the final one with tlast high, and the phase advances by phase_increment.
// With amplitude zero a frame gives no items and the phase holds, though the
// restart flag in in_tdata bit 0 still clears it. Timing: a taken frame is
// registered in stage 1, reads the table into stage 2 and enters the output
// serializer in stage 3, where its first item appears; the serializer sends
// one item per cycle while out_tready is high, and a silent frame retires
// from stage 1. New frames are taken while the serializer is still busy, until
// the three pipeline stages fill. Registers are written through the cfg port,
// which is always ready; write them only while the block is idle.
// ----------------------------------------------------------------------------
module sine_tone_generator_core #(
  parameter int MAX_CHANNELS       = stg_pkg::MAX_CHANNELS_DEF,
  parameter int SINE_TABLE_ENTRIES = stg_pkg::SINE_TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stg_pkg::CFG_DATA_W-1:0]    cfg_data,
  // frame requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] restart_phase, [7:1] zero
  // samples
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // [15:0] sample, [18:16] channel_index,
                                                        // [23:19] zero
  output logic                              out_tlast   // last_in_frame
);

  localparam int AW     = $clog2(SINE_TABLE_ENTRIES);
  localparam int NW     = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int PW     = stg_pkg::PHASE_W;
  localparam int SW     = stg_pkg::SAMPLE_W;
  localparam int CH_LIM = (MAX_CHANNELS < 15) ? MAX_CHANNELS : 15;
  localparam int CNT_W  = (CH_LIM > 1) ? $clog2(CH_LIM) : 1;

  // ---------------------------------------------------------------- registers
  logic [PW-1:0]                   phase_inc_r;
  logic [stg_pkg::AMP_W-1:0]       amplitude_r;
  logic [stg_pkg::CHAN_CNT_W-1:0]  chan_cnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= stg_pkg::PHASE_INC_RST;
      amplitude_r <= stg_pkg::AMPLITUDE_RST;
      chan_cnt_r  <= stg_pkg::CHAN_CNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stg_pkg::CFG_PHASE_INC:     phase_inc_r <= cfg_data;
        stg_pkg::CFG_AMPLITUDE:     amplitude_r <= cfg_data[stg_pkg::AMP_W-1:0];
        stg_pkg::CFG_CHANNEL_COUNT: chan_cnt_r  <= cfg_data[stg_pkg::CHAN_CNT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ------------------------------------------------------------ pipeline ctl
  logic v1_r, v2_r, v3_r;
  logic fire1, fire2, adv3;
  logic out_fire;
  logic amp_zero;

  assign amp_zero  = (amplitude_r == '0);
  assign out_fire  = out_tvalid && out_tready;
  assign adv3      = out_fire && out_tlast;
  // silent frames never enter stage 2, so they retire straight from stage 1
  assign fire2     = v2_r && (!v3_r || adv3);
  assign fire1     = v1_r && (!v2_r || fire2 || amp_zero);
  assign in_tready = !v1_r || fire1;

  // stage 1: frame request
  logic restart1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      restart1_r <= in_tdata[0];
    end
  end

  // ----------------------------------------------------------- phase memory
  // one-entry memory with a registered read, read every cycle; the value
  // written in the previous cycle is forwarded around the stale read
  logic [PW-1:0] phase_mem [1];
  logic [PW-1:0] ph_rd_r;
  logic [PW-1:0] fwd_data_r;
  logic          fwd_vld_r;
  logic          wr_seen_r;    // memory holds a written value
  logic          rd_valid_r;   // read register holds a written value
  logic [PW-1:0] phase_cur;
  logic [PW-1:0] phase_wdata;

  always_ff @(posedge clk) begin
    if (fire1) begin
      phase_mem[0] <= phase_wdata;
    end
    ph_rd_r <= phase_mem[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r  <= 1'b0;
      wr_seen_r  <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      fwd_vld_r  <= fire1;
      wr_seen_r  <= wr_seen_r || fire1;
      rd_valid_r <= wr_seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      fwd_data_r <= phase_wdata;
    end
  end

  always_comb begin
    if (restart1_r) begin
      phase_cur = '0;
    end else if (fwd_vld_r) begin
      phase_cur = fwd_data_r;
    end else if (rd_valid_r) begin
      phase_cur = ph_rd_r;
    end else begin
      phase_cur = '0;  // never written since reset
    end
  end

  // the phase holds on silent frames
  assign phase_wdata = amp_zero ? phase_cur : phase_cur + phase_inc_r;

  // table index is the top bits of phase times table size
  logic [PW+NW-1:0] idx_prod;
  logic [AW-1:0]    tbl_addr;

  assign idx_prod = (PW+NW)'(phase_cur) * (PW+NW)'(SINE_TABLE_ENTRIES);
  assign tbl_addr = idx_prod[PW +: AW];

  // stage 2: table read lands here
  logic signed [SW-1:0] sine_q;

  stg_sine_rom #(
    .ENTRIES (SINE_TABLE_ENTRIES)
  ) u_rom (
    .clk     (clk),
    .rd_en   (fire1),
    .rd_addr (tbl_addr),
    .rd_data (sine_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (fire1) begin
      v2_r <= !amp_zero;
    end else if (fire2) begin
      v2_r <= 1'b0;
    end
  end

  // amplitude scaling, truncated toward zero by working on the magnitude
  logic [stg_pkg::AMP_W-1:0]   sine_mag;
  logic [2*stg_pkg::AMP_W-1:0] scaled;
  logic [SW-1:0]               mag_ext;
  logic [SW-1:0]               sample_nxt;

  always_comb begin
    sine_mag   = sine_q[SW-1] ? stg_pkg::AMP_W'(-sine_q) : stg_pkg::AMP_W'(sine_q);
    scaled     = (2*stg_pkg::AMP_W)'(amplitude_r) * (2*stg_pkg::AMP_W)'(sine_mag);
    mag_ext    = SW'(scaled[2*stg_pkg::AMP_W-1 -: stg_pkg::AMP_W]);
    sample_nxt = sine_q[SW-1] ? -mag_ext : mag_ext;
  end

  // stage 3: output serializer, one item per channel
  logic [SW-1:0]    sample_r;
  logic [CNT_W-1:0] chan_r;
  logic [CNT_W-1:0] chan_last;
  logic [stg_pkg::CHAN_CNT_W-1:0] chans_m1;

  always_comb begin
    if (chan_cnt_r == '0) begin
      chans_m1 = '0;
    end else if (int'(chan_cnt_r) > MAX_CHANNELS) begin
      chans_m1 = stg_pkg::CHAN_CNT_W'(MAX_CHANNELS - 1);
    end else begin
      chans_m1 = chan_cnt_r - 1'b1;
    end
    chan_last = CNT_W'(chans_m1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r   <= 1'b0;
      chan_r <= '0;
    end else if (fire2) begin
      v3_r   <= 1'b1;
      chan_r <= '0;
    end else if (adv3) begin
      v3_r   <= 1'b0;
      chan_r <= '0;
    end else if (out_fire) begin
      chan_r <= chan_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tlast  = (chan_r == chan_last);
  assign out_tdata  = {5'b0, stg_pkg::CHAN_IDX_W'(chan_r), sample_r};

  // ------------------------------------------------------------- assertions
  // the next frame must see the phase just written back
  a_phase_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    fire1 |=> (fwd_vld_r && fwd_data_r == $past(phase_wdata)))
    else $error("phase forwarding lost the written value");

  // a frame entering the serializer starts at channel zero
  a_frame_start : assert property (@(posedge clk) disable iff (!rst_n)
    fire2 |=> (v3_r && chan_r == '0))
    else $error("serializer did not restart at channel zero");

  // the channel counter moves only on a taken item
  a_chan_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_fire) |=> (chan_r == $past(chan_r)))
    else $error("channel counter moved without an item taken");

endmodule
